[rtl/core/anbs_pkg.sv]
`timescale 1ns / 1ps

package anbs_pkg;

   // Width of the fields that come from the stream and go into a result word.
   localparam int UNIT_LENGTH_W = 21;
   localparam int PREFIX_W      = 3;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Byte history after reset: all ones, so no zero byte has been seen.
   localparam logic [23:0] HISTORY_RESET = 24'hFF_FFFF;
   localparam logic [7:0]  START_CODE_END = 8'h01;

   // Start code lengths.
   localparam logic [PREFIX_W-1:0] PREFIX_NONE  = 3'd0;
   localparam logic [PREFIX_W-1:0] PREFIX_SHORT = 3'd3;
   localparam logic [PREFIX_W-1:0] PREFIX_LONG  = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_PREFIX = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

   typedef enum logic [1:0] {
      PHASE_PREFIX = 2'b01,
      PHASE_UNIT   = 2'b10
   } phase_type;

   typedef enum logic {
      EVT_CLOSE = 1'b0,
      EVT_BAD   = 1'b1
   } evt_kind_type;

   // Everything the back needs to turn one event into its result words,
   // apart from the byte count, whose width follows the length limit.
   typedef struct packed {
      evt_kind_type        kind;
      logic                dual;
      logic [PREFIX_W-1:0] trail;
      logic [PREFIX_W-1:0] prefix;
      logic [7:0]          header_byte;
      logic                header_seen;
   } evt_meta_type;

endpackage

[rtl/core/anbs_channels.sv]
`timescale 1ns / 1ps

// Input channel: one stream byte per word.
interface anbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// Result channel: one unit descriptor per word.
interface anbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] unit_length;
   logic [2:0]  prefix_length;
   logic        forbidden_zero;
   logic [1:0]  ref_idc;
   logic [4:0]  unit_type;
   logic        has_header;
   logic [1:0]  status;
   logic        last_in_run;

   modport source (
      output valid, output unit_length, output prefix_length, output forbidden_zero,
      output ref_idc, output unit_type, output has_header, output status,
      output last_in_run, input ready
   );
   modport sink (
      input valid, input unit_length, input prefix_length, input forbidden_zero,
      input ref_idc, input unit_type, input has_header, input status,
      input last_in_run, output ready
   );
endinterface

[rtl/core/anbs_queue.sv]
`timescale 1ns / 1ps

module anbs_queue
   import anbs_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == CNTW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/anbs_front.sv]
`timescale 1ns / 1ps

module anbs_front
   import anbs_pkg::*;
#(
   parameter int MAX_UNIT_BYTES = 1048576,
   parameter int CW = $clog2(MAX_UNIT_BYTES + 6)
) (
   input  logic         clock,
   input  logic         reset,
   anbs_req_if.sink     req_chan,
   input  logic         queue_full,
   output logic         evt_push,
   output evt_meta_type evt_meta,
   output logic [CW-1:0] evt_count
);

   localparam logic [CW-1:0] COUNT_CAP = CW'(MAX_UNIT_BYTES + 5);

   logic [23:0]         hist_ff, hist_in;
   phase_type           phase_ff, phase_in;
   logic [1:0]          pcount_ff, pcount_in;
   logic [PREFIX_W-1:0] cur_pfx_ff, cur_pfx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [7:0]          hbyte_ff, hbyte_in;
   logic                hseen_ff, hseen_in;

   logic                accept;
   logic [7:0]          b;
   logic                eos;
   logic [2:0]          pc;
   logic                zero2, zero3, is_one;
   logic                four, three;
   logic [CW-1:0]       cnt_next;
   logic [PREFIX_W-1:0] sc;
   logic [7:0]          hbyte_now;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;
   assign b      = req_chan.data_byte;
   assign eos    = req_chan.end_of_stream;

   assign pc       = {1'b0, pcount_ff} + 3'd1;
   assign zero2    = (hist_ff[15:0] == 16'h0000);
   assign zero3    = (hist_ff == 24'h00_0000);
   assign is_one   = (b == START_CODE_END);
   assign four     = zero3 && is_one;
   assign three    = !four && zero2 && is_one;
   assign sc       = four ? PREFIX_LONG : PREFIX_SHORT;
   assign cnt_next = (count_ff < COUNT_CAP) ? count_ff + 1'b1 : COUNT_CAP;
   assign hbyte_now = hseen_ff ? hbyte_ff : b;

   always_comb begin
      hist_in    = hist_ff;
      phase_in   = phase_ff;
      pcount_in  = pcount_ff;
      cur_pfx_in = cur_pfx_ff;
      count_in   = count_ff;
      hbyte_in   = hbyte_ff;
      hseen_in   = hseen_ff;

      evt_push              = 1'b0;
      evt_meta.kind         = EVT_CLOSE;
      evt_meta.dual         = 1'b0;
      evt_meta.trail        = PREFIX_NONE;
      evt_meta.prefix       = PREFIX_NONE;
      evt_meta.header_byte  = 8'h00;
      evt_meta.header_seen  = 1'b0;
      evt_count             = '0;

      if (accept) begin
         hist_in = {hist_ff[15:0], b};
         if (phase_ff != PHASE_UNIT) begin
            if ((pc == 3'd3) && zero2 && is_one) begin
               // Short start code: the unit opens, and closes at once at end of stream.
               phase_in   = PHASE_UNIT;
               pcount_in  = 2'd0;
               cur_pfx_in = PREFIX_SHORT;
               count_in   = CW'(PREFIX_SHORT);
               hbyte_in   = 8'h00;
               hseen_in   = 1'b0;
               if (eos) begin
                  evt_push        = 1'b1;
                  evt_meta.prefix = PREFIX_SHORT;
                  evt_count       = CW'(PREFIX_SHORT);
               end
            end else if (pc == 3'd4) begin
               if (zero3 && is_one) begin
                  phase_in   = PHASE_UNIT;
                  pcount_in  = 2'd0;
                  cur_pfx_in = PREFIX_LONG;
                  count_in   = CW'(PREFIX_LONG);
                  hbyte_in   = 8'h00;
                  hseen_in   = 1'b0;
                  if (eos) begin
                     evt_push        = 1'b1;
                     evt_meta.prefix = PREFIX_LONG;
                     evt_count       = CW'(PREFIX_LONG);
                  end
               end else begin
                  // Neither form matched: report four consumed bytes and restart.
                  evt_push      = 1'b1;
                  evt_meta.kind = EVT_BAD;
                  evt_count     = CW'(PREFIX_LONG);
               end
            end else begin
               phase_in  = PHASE_PREFIX;
               pcount_in = pc[1:0];
               if (eos) begin
                  evt_push      = 1'b1;
                  evt_meta.kind = EVT_BAD;
                  evt_count     = CW'(pc);
               end
            end
         end else begin
            hbyte_in = hbyte_now;
            hseen_in = 1'b1;
            count_in = cnt_next;
            if (four || three) begin
               // The start code just seen closes this unit and opens the next one.
               evt_push             = 1'b1;
               evt_meta.dual        = eos;
               evt_meta.trail       = sc;
               evt_meta.prefix      = cur_pfx_ff;
               evt_meta.header_byte = hbyte_now;
               evt_meta.header_seen = 1'b1;
               evt_count            = cnt_next;
               phase_in   = PHASE_UNIT;
               pcount_in  = 2'd0;
               cur_pfx_in = sc;
               count_in   = CW'(sc);
               hbyte_in   = 8'h00;
               hseen_in   = 1'b0;
            end else if (eos) begin
               evt_push             = 1'b1;
               evt_meta.prefix      = cur_pfx_ff;
               evt_meta.header_byte = hbyte_now;
               evt_meta.header_seen = 1'b1;
               evt_count            = cnt_next;
            end
         end

         // End of stream or a failed prefix returns the parser to its reset state.
         if (eos || (evt_push && (evt_meta.kind == EVT_BAD))) begin
            hist_in    = HISTORY_RESET;
            phase_in   = PHASE_PREFIX;
            pcount_in  = 2'd0;
            cur_pfx_in = PREFIX_NONE;
            count_in   = '0;
            hbyte_in   = 8'h00;
            hseen_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= HISTORY_RESET;
         phase_ff   <= PHASE_PREFIX;
         pcount_ff  <= 2'd0;
         cur_pfx_ff <= PREFIX_NONE;
         count_ff   <= '0;
         hbyte_ff   <= 8'h00;
         hseen_ff   <= 1'b0;
      end else begin
         hist_ff    <= hist_in;
         phase_ff   <= phase_in;
         pcount_ff  <= pcount_in;
         cur_pfx_ff <= cur_pfx_in;
         count_ff   <= count_in;
         hbyte_ff   <= hbyte_in;
         hseen_ff   <= hseen_in;
      end
   end

endmodule

[rtl/core/anbs_back.sv]
`timescale 1ns / 1ps

module anbs_back
   import anbs_pkg::*;
#(
   parameter int MAX_UNIT_BYTES = 1048576,
   parameter int CW = $clog2(MAX_UNIT_BYTES + 6)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] limit,
   input  logic          evt_empty,
   input  evt_meta_type  evt_meta,
   input  logic [CW-1:0] evt_count,
   output logic          evt_pop,
   anbs_rsp_if.source    rsp_chan
);

   localparam logic [CW-1:0] COUNT_CAP = CW'(MAX_UNIT_BYTES + 5);

   logic                     second_ff, second_in;
   logic                     valid_ff, valid_in;
   logic [UNIT_LENGTH_W-1:0] len_ff, len_in;
   logic [PREFIX_W-1:0]      pfx_ff, pfx_in;
   logic [7:0]               hbyte_ff, hbyte_in;
   logic                     hdr_ff, hdr_in;
   logic [1:0]               status_ff, status_in;
   logic                     last_ff, last_in;

   logic                     load;
   logic [CW-1:0]            src_count;
   logic [PREFIX_W-1:0]      src_trail;
   logic [PREFIX_W-1:0]      src_pfx;
   logic                     src_hseen;
   logic [CW-1:0]            sub_len;
   logic                     over_limit;

   assign load = !valid_ff || rsp_chan.ready;

   // The second word of a pair is the unit made only of the closing start code.
   always_comb begin
      if (second_ff) begin
         src_count = CW'(evt_meta.trail);
         src_trail = PREFIX_NONE;
         src_pfx   = evt_meta.trail;
         src_hseen = 1'b0;
      end else begin
         src_count = evt_count;
         src_trail = evt_meta.trail;
         src_pfx   = evt_meta.prefix;
         src_hseen = evt_meta.header_seen;
      end
   end

   assign sub_len    = (src_count >= CW'(src_trail)) ? src_count - CW'(src_trail) : '0;
   assign over_limit = (sub_len > limit);

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      len_in    = len_ff;
      pfx_in    = pfx_ff;
      hbyte_in  = hbyte_ff;
      hdr_in    = hdr_ff;
      status_in = status_ff;
      last_in   = last_ff;
      evt_pop   = 1'b0;

      if (load) begin
         valid_in = !evt_empty;
         if (!evt_empty) begin
            hbyte_in = evt_meta.header_byte;
            if (evt_meta.kind == EVT_BAD) begin
               len_in    = UNIT_LENGTH_W'(evt_count);
               pfx_in    = PREFIX_NONE;
               hdr_in    = 1'b0;
               status_in = STATUS_BAD_PREFIX;
            end else if (src_count >= COUNT_CAP) begin
               // The counter saturated: the unit is reported at the limit.
               len_in    = UNIT_LENGTH_W'(limit);
               pfx_in    = src_pfx;
               hdr_in    = src_hseen;
               status_in = STATUS_TOO_LONG;
            end else begin
               len_in    = over_limit ? UNIT_LENGTH_W'(limit) : UNIT_LENGTH_W'(sub_len);
               pfx_in    = src_pfx;
               hdr_in    = src_hseen && (sub_len > CW'(src_pfx));
               status_in = over_limit ? STATUS_TOO_LONG : STATUS_OK;
            end
            if (evt_meta.dual && !second_ff) begin
               second_in = 1'b1;
               last_in   = 1'b0;
            end else begin
               second_in = 1'b0;
               last_in   = 1'b1;
               evt_pop   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      pfx_ff    <= pfx_in;
      hbyte_ff  <= hbyte_in;
      hdr_ff    <= hdr_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.unit_length    = len_ff;
   assign rsp_chan.prefix_length  = pfx_ff;
   assign rsp_chan.forbidden_zero = hdr_ff & hbyte_ff[7];
   assign rsp_chan.ref_idc        = hdr_ff ? hbyte_ff[6:5] : 2'b00;
   assign rsp_chan.unit_type      = hdr_ff ? hbyte_ff[4:0] : 5'b00000;
   assign rsp_chan.has_header     = hdr_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.last_in_run    = last_ff;

endmodule

[rtl/core/annexb_nal_unit_splitter.sv]
`timescale 1ns / 1ps

// Annex B NAL unit splitter. The block takes an H.264 Annex B byte stream one
// byte per word on req_chan and gives one descriptor word per NAL unit on
// rsp_chan: the unit length including its leading start code, the start code
// length (3 or 4), the forbidden, ref_idc and type fields of the first byte
// after the start code, a has_header flag and a status. Every unit must open
// with 00 00 01 or 00 00 00 01; a stream that does not gives a bad-prefix word
// holding the number of bytes the failed check consumed, and the check starts
// again. A unit closes at the next start code (the four-byte form wins) or at
// the byte flagged end_of_stream. A start code on the last byte gives two
// words, the closed unit and a unit made only of that start code; last_in_run
// marks the final word caused by one input byte. Lengths above the limit in
// csr_write_data (clipped to MAX_UNIT_BYTES) report the limit with the
// too-long status. The limit must be written only while the block is idle;
// the block itself does not enforce this. Rate: one byte is taken every clock
// while the result side keeps up. The front parser carries its whole state
// from byte to byte, and the result register emits one word per clock while
// rsp_chan is ready, so a byte that gives two words holds the result side for
// both; the four-entry event queue between them absorbs bursts.

module annexb_nal_unit_splitter
   import anbs_pkg::*;
#(
   parameter int MAX_UNIT_BYTES = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [20:0] csr_write_data,
   anbs_req_if.sink    req_chan,
   anbs_rsp_if.source  rsp_chan
);

   // The byte counter must hold the saturation point, MAX_UNIT_BYTES + 5.
   localparam int CW = $clog2(MAX_UNIT_BYTES + 6);
   localparam int LW = (CW > UNIT_LENGTH_W) ? CW : UNIT_LENGTH_W;
   localparam int RESET_LIMIT = (MAX_UNIT_BYTES < 1000000) ? MAX_UNIT_BYTES : 1000000;
   localparam int QW = $bits(evt_meta_type) + CW;

   // The limit is stored already clipped, so it always fits the counter width.
   logic [CW-1:0] limit_ff, limit_in;
   logic [LW-1:0] wide_data;

   assign wide_data = LW'(csr_write_data);
   assign limit_in  = (wide_data < LW'(MAX_UNIT_BYTES)) ? CW'(wide_data)
                                                        : CW'(MAX_UNIT_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CW'(RESET_LIMIT);
      end else if (csr_write_enable) begin
         limit_ff <= limit_in;
      end
   end

   // Front: parses bytes and posts one event for each byte that closes a unit or fails the prefix check.
   logic         queue_full;
   logic         queue_empty;
   logic         evt_push;
   logic         evt_pop;
   evt_meta_type push_meta;
   logic [CW-1:0] push_count;
   evt_meta_type head_meta;
   logic [CW-1:0] head_count;
   logic [QW-1:0] head_word;

   anbs_front #(
      .MAX_UNIT_BYTES (MAX_UNIT_BYTES),
      .CW             (CW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .evt_push   (evt_push),
      .evt_meta   (push_meta),
      .evt_count  (push_count)
   );

   anbs_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data ({push_meta, push_count}),
      .full      (queue_full),
      .pop       (evt_pop),
      .pop_data  (head_word),
      .empty     (queue_empty)
   );

   assign head_meta  = evt_meta_type'(head_word[QW-1:CW]);
   assign head_count = head_word[CW-1:0];

   // Back: turns each event into one or two descriptor words.
   anbs_back #(
      .MAX_UNIT_BYTES (MAX_UNIT_BYTES),
      .CW             (CW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .evt_empty (queue_empty),
      .evt_meta  (head_meta),
      .evt_count (head_count),
      .evt_pop   (evt_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
